FILE: rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the prime count classifier: value and count
// widths, result packing, and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 16;
	localparam int DIV_STEPS = 8;

	localparam int OUT_W          = 24;
	localparam int OUT_WHOLE_BIT  = 0;
	localparam int OUT_DIV3_BIT   = 1;
	localparam int OUT_PRIME_BIT  = 2;
	localparam int OUT_COUNT_LSB  = 3;
	localparam int OUT_ASC_BIT    = OUT_COUNT_LSB + COUNT_W;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel3;
		logic div_step;
		logic set_div3;
		logic set_prime;
		logic next_div;
		logic commit;
	} pcc_cmd_t;

	typedef struct packed {
		logic whole;
		logic ge2;
		logic div_last;
		logic rem_zero;
		logic sq_gt_n;
	} pcc_sts_t;

endpackage

FILE: rtl/core/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl
// Controller of the classifier: sequences the divisibility-by-three check and
// the trial-division loop, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pcc_ctrl
	import pcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  pcc_sts_t sts,
	output pcc_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV3,
		ST_DIV3_END,
		ST_TEST,
		ST_TRIAL,
		ST_TRIAL_END,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.whole) begin
					cmd.div_start = 1'b1;
					cmd.div_sel3  = 1'b1;
					state_nxt     = ST_DIV3;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_DIV3: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_DIV3_END;
				end
			end
			ST_DIV3_END: begin
				cmd.set_div3 = 1'b1;
				state_nxt    = sts.ge2 ? ST_TEST : ST_FINISH;
			end
			ST_TEST: begin
				if (sts.sq_gt_n) begin
					cmd.set_prime = 1'b1;
					state_nxt     = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_TRIAL_END;
				end
			end
			ST_TRIAL_END: begin
				if (sts.rem_zero) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.next_div = 1'b1;
					state_nxt    = ST_TEST;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/pcc_dp.sv
// ----------------------------------------------------------------------------
// pcc_dp
// Datapath of the classifier: input capture, an iterative remainder unit that
// takes DIV_STEPS dividend bits per cycle, the trial divisor and its square,
// the per-list state and the result register.
// ----------------------------------------------------------------------------
module pcc_dp
	import pcc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pcc_cmd_t           cmd,
	output pcc_sts_t           sts,
	input  logic [VALUE_W-1:0] in_value,
	input  logic               in_start,
	output logic [OUT_W-1:0]   out_data
);

	localparam int IP_W   = (FRAC_BITS < VALUE_W) ? (VALUE_W - FRAC_BITS) : 1;
	localparam int D_W    = (IP_W + 1) / 2 + 1;
	localparam int SQ_W   = IP_W + 2;
	localparam int NCHUNK = (IP_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int PAD_W  = NCHUNK * DIV_STEPS;
	localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam logic [VALUE_W:0]   FM_WIDE   = (33'd1 << FRAC_BITS) - 33'd1;
	localparam logic [VALUE_W-1:0] FRAC_MASK = FM_WIDE[VALUE_W-1:0];

	logic [VALUE_W-1:0] ip_full;
	logic [IP_W-1:0]    ip_in;
	logic [IP_W-1:0]    mag_in;

	logic [VALUE_W-1:0] value_q;
	logic               start_q;
	logic               whole_q;
	logic [IP_W-1:0]    mag_q;
	logic               ge2_q;
	logic [D_W-1:0]     d_q;
	logic [SQ_W-1:0]    sq_q;
	logic               div3_q;
	logic               prime_q;
	logic [PAD_W-1:0]   dvd_q;
	logic [D_W-1:0]     rem_q;
	logic [D_W-1:0]     div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [D_W-1:0]     rem_nxt;

	logic [VALUE_W-1:0] prev_q;
	logic               have_prev_q;
	logic               asc_q;
	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] tot_base;
	logic [COUNT_W-1:0] tot_new;
	logic               asc_new;
	logic [OUT_W-1:0]   out_q;

	assign ip_full = $signed(in_value) >>> FRAC_BITS;
	assign ip_in   = ip_full[IP_W-1:0];
	assign mag_in  = ip_in[IP_W-1] ? (~ip_in + IP_W'(1)) : ip_in;

	always_comb begin
		logic [D_W:0] r;
		r = {1'b0, rem_q};
		for (int k = 0; k < DIV_STEPS; k++) begin
			r = {r[D_W-1:0], dvd_q[PAD_W-1-k]};
			if (r >= {1'b0, div_q}) begin
				r = r - {1'b0, div_q};
			end
		end
		rem_nxt = r[D_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_value;
			start_q <= in_start;
			whole_q <= ((in_value & FRAC_MASK) == '0);
			mag_q   <= mag_in;
			ge2_q   <= !ip_in[IP_W-1] && (mag_in > IP_W'(1));
			d_q     <= D_W'(2);
			sq_q    <= SQ_W'(4);
			div3_q  <= 1'b0;
			prime_q <= 1'b0;
		end
		if (cmd.div_start) begin
			dvd_q <= PAD_W'(mag_q);
			rem_q <= '0;
			cnt_q <= '0;
			div_q <= cmd.div_sel3 ? D_W'(3) : d_q;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_q << DIV_STEPS;
			rem_q <= rem_nxt;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.set_div3) begin
			div3_q <= (rem_q == '0);
		end
		if (cmd.set_prime) begin
			prime_q <= 1'b1;
		end
		if (cmd.next_div) begin
			d_q  <= d_q + D_W'(1);
			sq_q <= sq_q + SQ_W'({d_q, 1'b0}) + SQ_W'(1);
		end
		if (cmd.commit) begin
			out_q <= {{(OUT_W - OUT_ASC_BIT - 1){1'b0}}, asc_new, tot_new,
				prime_q, div3_q, whole_q};
		end
	end

	always_comb begin
		tot_base = start_q ? '0 : total_q;
		tot_new  = (prime_q && (tot_base != '1)) ? (tot_base + COUNT_W'(1)) : tot_base;
		asc_new  = (start_q || asc_q) &&
			!(!start_q && have_prev_q && ($signed(prev_q) > $signed(value_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			asc_q       <= 1'b1;
			total_q     <= '0;
		end else if (cmd.commit) begin
			prev_q      <= value_q;
			have_prev_q <= 1'b1;
			asc_q       <= asc_new;
			total_q     <= tot_new;
		end
	end

	assign sts.whole    = whole_q;
	assign sts.ge2      = ge2_q;
	assign sts.div_last = (cnt_q == CNT_W'(NCHUNK - 1));
	assign sts.rem_zero = (rem_q == '0);
	assign sts.sq_gt_n  = (sq_q > SQ_W'(mag_q));
	assign out_data     = out_q;

endmodule

FILE: rtl/core/prime_count_classifier.sv
// ----------------------------------------------------------------------------
// prime_count_classifier
// Classifies a stream of signed fixed-point list elements: whole, divisible by
// three, prime by trial division, running prime count and ascending order.
// ----------------------------------------------------------------------------
// One element enters on the s_ channel: s_tdata carries the value and s_tuser
// flags the first element of a new list, which clears the prime count and the
// ascending state. One result leaves on the m_ channel for every element.
// Elements are handled one at a time. A non-whole element goes from the check
// state straight to the finish state. A whole element first runs its integer
// part n through the remainder unit for the divisibility-by-three check, then
// tries divisors 2, 3 and upward while the divisor square stays at or below n.
// Each try runs the test, trial and trial-end states, and in the trial state
// the remainder unit retires eight dividend bits per cycle. The next element
// is accepted once the result has been committed and the controller has
// returned to idle.
// The result sits in an output register, and the next element is accepted
// while it waits; when m_tready stays low, the following result is held
// inside until the register is free. Reset empties the output, returns the
// controller to idle and starts an empty ascending list with a zero count.
// ----------------------------------------------------------------------------
module prime_count_classifier
	import pcc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// value[31:0]
	input  logic [VALUE_W-1:0] s_tdata,
	// list_start[0]
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// is_whole[0], divisible_by_three[1], is_prime[2], prime_count[18:3],
	// ascending[19], zero fill[23:20]
	output logic [OUT_W-1:0]   m_tdata
);

	pcc_cmd_t cmd;
	pcc_sts_t sts;

	pcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcc_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_value (s_tdata),
		.in_start (s_tuser),
		.out_data (m_tdata)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Controller accepted a transaction while busy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.commit))
		else $error("Result became valid without a commit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_PRIME_BIT] |-> m_tdata[OUT_WHOLE_BIT])
		else $error("Prime result reported for a non-whole value.");

endmodule

FILE: tb/sv/tb_prime_count_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prime_count_classifier
// Self-checking testbench for the prime count classifier. A short table of
// directed elements and about nine hundred random elements grouped into lists
// are streamed in. Each accepted element is classified by a local predictor,
// and every transaction on the result side is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_prime_count_classifier
	import pcc_pkg::*;
();

	localparam int FRAC       = 16;
	localparam int RAND_ITEMS = 900;
	localparam int SETTLE     = 800;

	typedef struct packed {
		logic               whole;
		logic               div3;
		logic               prime;
		logic [COUNT_W-1:0] count;
		logic               asc;
	} verdict_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               start;
		logic               typed;
		verdict_t           res;
	} dir_row_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata  = '0;
	logic               s_tuser  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;

	logic               row_typed = 1'b0;
	verdict_t           row_res   = '0;
	int                 rx_left   = 0;
	int                 burst_left = 0;

	logic signed [VALUE_W-1:0] last_value  = '0;
	bit                        seen_value  = 1'b0;
	bit                        asc_state   = 1'b1;
	logic [COUNT_W-1:0]        prime_tally = '0;

	verdict_t pending_verdicts[$];

	int errors      = 0;
	int items_in    = 0;
	int results_out = 0;
	int whole_out   = 0;
	int primes_out  = 0;
	int peak_count  = 0;

	prime_count_classifier #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(64'd100_000_000);
		$display("Timeout with %0d results still pending.", pending_verdicts.size());
		$display("Regression FAIL");
		$finish;
	end

	function automatic verdict_t make_verdict(bit w, bit d, bit p, int c, bit a);
		verdict_t v;
		v.whole = w;
		v.div3  = d;
		v.prime = p;
		v.count = c[COUNT_W-1:0];
		v.asc   = a;
		return v;
	endfunction

	function automatic bit trial_prime(longint n);
		if (n < 2)
			return 1'b0;
		for (longint d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic verdict_t classify_element(logic [VALUE_W-1:0] raw, logic start);
		verdict_t v;
		longint   ip;
		v = '0;
		if (start) begin
			prime_tally = '0;
			asc_state   = 1'b1;
			seen_value  = 1'b0;
		end
		v.whole = (raw[FRAC-1:0] == '0);
		if (v.whole) begin
			ip      = longint'($signed(raw)) / (longint'(1) << FRAC);
			v.div3  = (ip % 3) == 0;
			v.prime = trial_prime(ip);
		end
		if (v.prime && prime_tally != '1)
			prime_tally++;
		if (seen_value && last_value > $signed(raw))
			asc_state = 1'b0;
		last_value = raw;
		seen_value = 1'b1;
		v.count    = prime_tally;
		v.asc      = asc_state;
		return v;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("Mismatch at %0t on %s: got %0h, expected %0h.", $time, field, got, want);
	endtask

	always @(posedge clk) begin : monitor
		verdict_t got;
		verdict_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = classify_element(s_tdata, s_tuser);
				pending_verdicts.push_back(row_typed ? row_res : want);
				items_in++;
			end
			if (m_tvalid && m_tready) begin
				got.whole = m_tdata[OUT_WHOLE_BIT];
				got.div3  = m_tdata[OUT_DIV3_BIT];
				got.prime = m_tdata[OUT_PRIME_BIT];
				got.count = m_tdata[OUT_COUNT_LSB +: COUNT_W];
				got.asc   = m_tdata[OUT_ASC_BIT];
				results_out++;
				if (pending_verdicts.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata, 0);
				end else begin
					want = pending_verdicts.pop_front();
					if (got.whole != want.whole)
						report_mismatch("is_whole", got.whole, want.whole);
					if (got.div3 != want.div3)
						report_mismatch("divisible_by_three", got.div3, want.div3);
					if (got.prime != want.prime)
						report_mismatch("is_prime", got.prime, want.prime);
					if (got.count != want.count)
						report_mismatch("prime_count", got.count, want.count);
					if (got.asc != want.asc)
						report_mismatch("ascending", got.asc, want.asc);
				end
				whole_out  += got.whole;
				primes_out += got.prime;
				if (got.count > peak_count)
					peak_count = got.count;
			end
		end
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			if ($urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
					$urandom_range(0, 8);
			end else begin
				m_tready <= 1'b1;
				rx_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) :
					$urandom_range(0, 15);
			end
		end else begin
			rx_left--;
		end
	end

	task automatic send_element(logic [VALUE_W-1:0] value, logic start, logic typed,
		verdict_t res);
		s_tvalid  <= 1'b1;
		s_tdata   <= value;
		s_tuser   <= start;
		row_typed <= typed;
		row_res   <= res;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
				$urandom_range(0, 16);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int          sel;
		logic [15:0] ip;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			ip = 16'($urandom_range(0, 300));
			if ($urandom_range(0, 9) == 0)
				ip = -ip;
			return {ip, 16'h0000};
		end
		if (sel < 50)
			return {16'($urandom), 16'h0000};
		if (sel < 55)
			return {16'h7F00 | 16'($urandom_range(0, 255)), 16'h0000};
		if (sel < 75)
			return {16'($urandom), 16'($urandom_range(1, 65535))};
		return $urandom;
	endfunction

	initial begin : stimulus
		dir_row_t           dir_rows[$];
		logic [VALUE_W-1:0] cur;
		longint             nxt;
		longint             step;
		int                 sel;
		int                 list_left;
		bit                 rising;
		logic               start;

		// Typed rows: values right after reset, the extremes and fresh lists.
		dir_rows.push_back({32'h0000_0000, 1'b0, 1'b1, make_verdict(1, 1, 0, 0, 1)});
		dir_rows.push_back({32'h0002_0000, 1'b0, 1'b1, make_verdict(1, 0, 1, 1, 1)});
		dir_rows.push_back({32'h7FFF_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h7FFF_FFFF, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h8000_0000, 1'b1, 1'b1, make_verdict(1, 0, 0, 0, 1)});
		dir_rows.push_back({32'hFFFF_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'hFFFD_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0000_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'hFFFE_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0000_8000, 1'b1, 1'b1, make_verdict(0, 0, 0, 0, 1)});
		dir_rows.push_back({32'h0003_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0004_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h7FED_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0000_FFFF, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'hFFFF_FFFF, 1'b1, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0019_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0006_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0005_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0007_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0009_0000, 1'b0, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0001_0000, 1'b1, 1'b0, verdict_t'('0)});
		dir_rows.push_back({32'h0002_0000, 1'b0, 1'b0, verdict_t'('0)});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_element(dir_rows[i].value, dir_rows[i].start, dir_rows[i].typed,
				dir_rows[i].res);
			pace_sender();
		end
		wait_drained();

		// Random lists: most climb in small steps, the rest are scattered values.
		list_left = 0;
		rising    = 1'b0;
		cur       = '0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			start = 1'b0;
			if (list_left == 0) begin
				list_left = $urandom_range(1, 30);
				rising    = $urandom_range(0, 99) < 65;
				start     = $urandom_range(0, 9) != 0;
				cur       = pick_value();
			end else if (rising) begin
				sel = $urandom_range(0, 99);
				if (sel < 20)
					step = 0;
				else if (sel < 60)
					step = longint'($urandom_range(1, 40)) << 16;
				else if (sel < 95)
					step = $urandom_range(1, 32'h3FFFF);
				else
					step = -longint'($urandom_range(1, 32'h40000));
				nxt = longint'($signed(cur)) + step;
				cur = (nxt > 64'sh7FFF_FFFF || nxt < -64'sh8000_0000) ? pick_value() :
					nxt[VALUE_W-1:0];
			end else begin
				cur = pick_value();
			end
			list_left--;
			send_element(cur, start, 1'b0, '0);
			pace_sender();
			if (i % 300 == 299)
				wait_drained();
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("Summary: %0d elements sent, %0d results checked, %0d whole, %0d prime.",
			items_in, results_out, whole_out, primes_out);
		$display("Summary: the largest prime count seen within one list was %0d.",
			peak_count);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
